### sv/slsh_pkg.sv
package slsh_pkg;

  localparam int SLOPE_FACTOR = 3000;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GRADIENT_SCALE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AMBIENT_LEVEL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_Z        = 3'd5;

  localparam logic [31:0] GRADIENT_RESET = 32'd65536;
  localparam logic [15:0] AMBIENT_RESET  = 16'd0;
  localparam logic [15:0] SOURCE_RESET   = 16'd4096;
  localparam logic [15:0] LIGHT_X_RESET  = 16'd0;
  localparam logic [15:0] LIGHT_Y_RESET  = 16'd0;
  localparam logic [15:0] LIGHT_Z_RESET  = 16'd16384;

  // normal magnitude dividend: |slope| * 3000 fits 43 bits, then 16 fraction bits
  localparam int PROD_W  = 43;
  localparam int NDIV_W  = PROD_W + 16;
  localparam int NORM_W  = 31;
  localparam int BLEN_W  = 7;
  localparam int DOT_W   = 50;
  localparam int CDIV_W  = 48;
  localparam int COS_W   = 18;
  localparam int ONE_Q16 = 65536;

endpackage

### sv/slsh_pdiv.sv
module slsh_pdiv import slsh_pkg::*; #(
  parameter int NW = NDIV_W,
  parameter int DW = 32,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [NW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  // one quotient bit per stage, dividend shifts out as quotient shifts in
  logic          v [0:NW];
  logic [NW-1:0] n [0:NW];
  logic [DW-1:0] r [0:NW];
  logic [DW-1:0] d [0:NW];
  logic [SW-1:0] s [0:NW];

  assign v[0] = in_valid;
  assign n[0] = in_num;
  assign r[0] = '0;
  assign d[0] = in_den;
  assign s[0] = in_side;

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    always_comb begin
      trial = {r[k], n[k][NW-1]};
      diff  = trial - {1'b0, d[k]};
      ge    = trial >= {1'b0, d[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n[k+1] <= {n[k][NW-2:0], ge};
        r[k+1] <= ge ? diff[DW-1:0] : trial[DW-1:0];
        d[k+1] <= d[k];
        s[k+1] <= s[k];
      end
    end
  end

  assign out_valid = v[NW];
  assign out_quo   = n[NW];
  assign out_side  = s[NW];

endmodule

### sv/slope_light_shader_unit.sv
// throughput: one item per cycle; the whole pipeline advances while the output
// register is empty or being taken, so a stall holds every stage in place
// the depth comes from two bit-per-stage dividers (59 and 48 stages) and a
// 32-stage square root; rst clears all valid bits and loads the register defaults
module slope_light_shader_unit import slsh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [63:0]          s_axis_tdata,   // slope_x, slope_y
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,   // brightness
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] gradient_scale;
  logic [15:0] ambient_level;
  logic [15:0] source_level;
  logic [15:0] light_x;
  logic [15:0] light_y;
  logic [15:0] light_z;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gradient_scale <= GRADIENT_RESET;
      ambient_level  <= AMBIENT_RESET;
      source_level   <= SOURCE_RESET;
      light_x        <= LIGHT_X_RESET;
      light_y        <= LIGHT_Y_RESET;
      light_z        <= LIGHT_Z_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GRADIENT_SCALE: gradient_scale <= cfg_data;
        REG_AMBIENT_LEVEL:  ambient_level  <= cfg_data[15:0];
        REG_SOURCE_LEVEL:   source_level   <= cfg_data[15:0];
        REG_LIGHT_X:        light_x        <= cfg_data[15:0];
        REG_LIGHT_Y:        light_y        <= cfg_data[15:0];
        REG_LIGHT_Z:        light_z        <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // input register
  logic        a_valid;
  logic [31:0] a_sx;
  logic [31:0] a_sy;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_sx <= s_axis_tdata[31:0];
      a_sy <= s_axis_tdata[63:32];
    end
  end

  // magnitude times slope factor
  logic        b_valid;
  logic [PROD_W-1:0] b_px;
  logic [PROD_W-1:0] b_py;
  logic        b_negx;
  logic        b_negy;
  logic [31:0] magx;
  logic [31:0] magy;
  logic [43:0] px_full;
  logic [43:0] py_full;

  always_comb begin
    magx    = a_sx[31] ? (~a_sx + 32'd1) : a_sx;
    magy    = a_sy[31] ? (~a_sy + 32'd1) : a_sy;
    px_full = 44'(magx) * 44'(SLOPE_FACTOR);
    py_full = 44'(magy) * 44'(SLOPE_FACTOR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_px   <= px_full[PROD_W-1:0];
      b_py   <= py_full[PROD_W-1:0];
      b_negx <= !a_sx[31] && (a_sx != 32'd0);
      b_negy <= !a_sy[31] && (a_sy != 32'd0);
    end
  end

  // normal magnitudes in q.16
  logic [31:0]       gdiv;
  logic              dx_valid;
  logic              dy_valid;
  logic [NDIV_W-1:0] dx_quo;
  logic [NDIV_W-1:0] dy_quo;
  logic              dx_neg;
  logic              dy_neg;

  assign gdiv = (gradient_scale == 32'd0) ? 32'd1 : gradient_scale;

  slsh_pdiv #(.NW(NDIV_W), .DW(32), .SW(1)) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_valid),
    .in_num   ({b_px, 16'd0}),
    .in_den   (gdiv),
    .in_side  (b_negx),
    .out_valid(dx_valid),
    .out_quo  (dx_quo),
    .out_side (dx_neg)
  );

  slsh_pdiv #(.NW(NDIV_W), .DW(32), .SW(1)) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_valid),
    .in_num   ({b_py, 16'd0}),
    .in_den   (gdiv),
    .in_side  (b_negy),
    .out_valid(dy_valid),
    .out_quo  (dy_quo),
    .out_side (dy_neg)
  );

  // largest magnitude
  logic              c1_valid;
  logic [NDIV_W-1:0] c1_qx;
  logic [NDIV_W-1:0] c1_qy;
  logic [NDIV_W-1:0] c1_max;
  logic              c1_negx;
  logic              c1_negy;
  logic [NDIV_W-1:0] mxy;

  always_comb begin
    mxy = (dx_quo > dy_quo) ? dx_quo : dy_quo;
    if (mxy < NDIV_W'(ONE_Q16)) begin
      mxy = NDIV_W'(ONE_Q16);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
    end else if (adv) begin
      c1_valid <= dx_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1_qx   <= dx_quo;
      c1_qy   <= dy_quo;
      c1_max  <= mxy;
      c1_negx <= dx_neg;
      c1_negy <= dy_neg;
    end
  end

  // bit length of the largest magnitude
  logic              c2_valid;
  logic [NDIV_W-1:0] c2_qx;
  logic [NDIV_W-1:0] c2_qy;
  logic [BLEN_W-1:0] c2_blen;
  logic              c2_negx;
  logic              c2_negy;
  logic [BLEN_W-1:0] blen;

  always_comb begin
    blen = '0;
    for (int i = 0; i < NDIV_W; i++) begin
      if (c1_max[i]) begin
        blen = BLEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_valid <= 1'b0;
    end else if (adv) begin
      c2_valid <= c1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_qx   <= c1_qx;
      c2_qy   <= c1_qy;
      c2_blen <= blen;
      c2_negx <= c1_negx;
      c2_negy <= c1_negy;
    end
  end

  // normalize so the largest magnitude has bit length 31
  logic              c3_valid;
  logic [NORM_W-1:0] c3_nx;
  logic [NORM_W-1:0] c3_ny;
  logic [NORM_W-1:0] c3_nz;
  logic              c3_negx;
  logic              c3_negy;
  logic [NORM_W-1:0] nx;
  logic [NORM_W-1:0] ny;
  logic [NORM_W-1:0] nz;
  logic [NDIV_W-1:0] qz;
  logic [BLEN_W-1:0] lsh;
  logic [BLEN_W-1:0] rsh;

  always_comb begin
    qz  = NDIV_W'(ONE_Q16);
    lsh = BLEN_W'(NORM_W) - c2_blen;
    rsh = c2_blen - BLEN_W'(NORM_W);
    if (c2_blen < BLEN_W'(NORM_W)) begin
      nx = NORM_W'(c2_qx << lsh);
      ny = NORM_W'(c2_qy << lsh);
      nz = NORM_W'(qz << lsh);
    end else begin
      nx = NORM_W'(c2_qx >> rsh);
      ny = NORM_W'(c2_qy >> rsh);
      nz = NORM_W'(qz >> rsh);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c3_valid <= 1'b0;
    end else if (adv) begin
      c3_valid <= c2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3_nx   <= nx;
      c3_ny   <= ny;
      c3_nz   <= nz;
      c3_negx <= c2_negx;
      c3_negy <= c2_negy;
    end
  end

  // products with the light and squares
  logic               d_valid;
  logic signed [47:0] d_tx;
  logic signed [47:0] d_ty;
  logic signed [47:0] d_tz;
  logic [61:0]        d_sxx;
  logic [61:0]        d_syy;
  logic [61:0]        d_szz;
  logic               d_negx;
  logic               d_negy;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tx   <= 48'($signed({1'b0, c3_nx})) * 48'($signed(light_x));
      d_ty   <= 48'($signed({1'b0, c3_ny})) * 48'($signed(light_y));
      d_tz   <= 48'($signed({1'b0, c3_nz})) * 48'($signed(light_z));
      d_sxx  <= 62'(c3_nx) * 62'(c3_nx);
      d_syy  <= 62'(c3_ny) * 62'(c3_ny);
      d_szz  <= 62'(c3_nz) * 62'(c3_nz);
      d_negx <= c3_negx;
      d_negy <= c3_negy;
    end
  end

  // dot product and squared length
  logic              e_valid;
  logic [CDIV_W-1:0] e_num;
  logic [63:0]       e_sumsq;
  logic signed [DOT_W-1:0] dot;
  logic signed [DOT_W-1:0] ex;
  logic signed [DOT_W-1:0] ey;

  always_comb begin
    ex  = d_negx ? -DOT_W'(d_tx) : DOT_W'(d_tx);
    ey  = d_negy ? -DOT_W'(d_ty) : DOT_W'(d_ty);
    dot = ex + ey + DOT_W'(d_tz);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_num   <= (dot > 0) ? dot[CDIV_W-1:0] : '0;
      e_sumsq <= 64'(d_sxx) + 64'(d_syy) + 64'(d_szz);
    end
  end

  // square root, two radicand bits per stage
  localparam int SQ_N = 32;

  logic              sq_v   [0:SQ_N];
  logic [63:0]       sq_x   [0:SQ_N];
  logic [63:0]       sq_r   [0:SQ_N];
  logic [CDIV_W-1:0] sq_num [0:SQ_N];

  assign sq_v[0]   = e_valid;
  assign sq_x[0]   = e_sumsq;
  assign sq_r[0]   = '0;
  assign sq_num[0] = e_num;

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'd1 << (62 - 2 * k);
    logic [64:0] trial;
    logic        take;

    always_comb begin
      trial = {1'b0, sq_r[k]} + {1'b0, BITV};
      take  = {1'b0, sq_x[k]} >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_v[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v[k+1] <= sq_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_x[k+1]   <= take ? (sq_x[k] - trial[63:0]) : sq_x[k];
        sq_r[k+1]   <= take ? ((sq_r[k] >> 1) + BITV) : (sq_r[k] >> 1);
        sq_num[k+1] <= sq_num[k];
      end
    end
  end

  logic [31:0] len;
  assign len = sq_r[SQ_N][31:0];

  // cosine in q4.14
  logic              cd_valid;
  logic [CDIV_W-1:0] cd_quo;
  logic              cd_pos;

  slsh_pdiv #(.NW(CDIV_W), .DW(32), .SW(1)) u_div_cos (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (sq_v[SQ_N]),
    .in_num   (sq_num[SQ_N]),
    .in_den   (len),
    .in_side  (sq_num[SQ_N] != '0),
    .out_valid(cd_valid),
    .out_quo  (cd_quo),
    .out_side (cd_pos)
  );

  // source times cosine
  logic        h_valid;
  logic [33:0] h_prod;
  logic [COS_W-1:0] cosq;

  assign cosq = cd_pos ? cd_quo[COS_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_prod <= 34'(source_level) * 34'(cosq);
    end
  end

  // ambient add, saturate, output register
  logic [20:0] brsum;
  assign brsum = 21'(ambient_level) + 21'(h_prod[33:14]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= (brsum > 21'd65535) ? 16'hFFFF : brsum[15:0];
    end
  end

  a_div_lanes_aligned: assert property (@(posedge clk) disable iff (rst)
    dx_valid == dy_valid)
    else $error("x and y divider lanes out of step");

  a_len_normalized: assert property (@(posedge clk) disable iff (rst)
    sq_v[SQ_N] |-> (len[31:30] != 2'b00))
    else $error("normal length below normalized range");

  a_out_clear_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

### tb/slope_light_shader_unit_tb.sv
`timescale 1ns / 100ps

module slope_light_shader_unit_tb;
  import slsh_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam int ITEMS_PER_PHASE = 230;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  logic [31:0] grad_q16;
  logic [15:0] ambient_q12;
  logic [15:0] source_q12;
  logic signed [15:0] lx_q14;
  logic signed [15:0] ly_q14;
  logic signed [15:0] lz_q14;

  logic [15:0] brightness_q[$];
  int errors;
  bit burst;

  typedef struct {
    logic [31:0] sx;
    logic [31:0] sy;
    bit known;
    logic [15:0] brightness;
  } shade_row_t;

  shade_row_t directed_rows[] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 16'd4096},
    '{32'h7fff_ffff, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h8000_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'h7fff_ffff, 1'b0, 16'd0},
    '{32'h0000_0000, 32'h8000_0000, 1'b0, 16'd0},
    '{32'h7fff_ffff, 32'h7fff_ffff, 1'b0, 16'd0},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, 16'd0},
    '{32'h7fff_ffff, 32'h8000_0000, 1'b0, 16'd0},
    '{32'h0000_0001, 32'hffff_ffff, 1'b0, 16'd0},
    '{32'hffff_ffff, 32'h0000_0001, 1'b0, 16'd0},
    '{32'h0001_0000, 32'h0000_0000, 1'b0, 16'd0},
    '{32'h0000_0000, 32'hffff_0000, 1'b0, 16'd0},
    '{32'h0000_0016, 32'h0000_0016, 1'b0, 16'd0},
    '{32'hffff_ffea, 32'h0000_0016, 1'b0, 16'd0},
    '{32'h5555_5555, 32'haaaa_aaaa, 1'b0, 16'd0},
    '{32'haaaa_aaaa, 32'h5555_5555, 1'b0, 16'd0}
  };

  slope_light_shader_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned normal_q16(logic [31:0] s, longint unsigned g,
                                                 output bit neg);
    longint unsigned mag;
    if (s[31]) begin
      mag = {32'd0, (~s) + 32'd1};
      neg = 1'b0;
    end else begin
      mag = {32'd0, s};
      neg = (s != 0);
    end
    return ((mag * SLOPE_FACTOR) << 16) / g;
  endfunction

  function automatic longint unsigned fit_31(longint unsigned v, int b);
    if (b < 31) return v << (31 - b);
    if (b > 31) return v >> (b - 31);
    return v;
  endfunction

  function automatic logic [15:0] shade(logic [31:0] sx, logic [31:0] sy);
    longint unsigned g, qx, qy, qz, m, len, cosq, br;
    longint tx, ty, tz, num;
    bit nx, ny;
    int b;
    g = (grad_q16 == 0) ? 64'd1 : {32'd0, grad_q16};
    qx = normal_q16(sx, g, nx);
    qy = normal_q16(sy, g, ny);
    qz = ONE_Q16;
    m = qz;
    if (qx > m) m = qx;
    if (qy > m) m = qy;
    b = 0;
    while (m != 0) begin
      b++;
      m >>= 1;
    end
    qx = fit_31(qx, b);
    qy = fit_31(qy, b);
    qz = fit_31(qz, b);
    tx = longint'(qx) * longint'(lx_q14);
    ty = longint'(qy) * longint'(ly_q14);
    tz = longint'(qz) * longint'(lz_q14);
    num = (nx ? -tx : tx) + (ny ? -ty : ty) + tz;
    len = int_sqrt(qx * qx + qy * qy + qz * qz);
    cosq = 0;
    if (num > 0 && len != 0) cosq = longint'(num) / len;
    br = ambient_q12 + ((source_q12 * cosq) >> 14);
    if (br > 65535) br = 65535;
    return br[15:0];
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    bit r;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      r = cfg_ready;
      @(posedge clk);
    end while (!r);
    cfg_valid <= 1'b0;
    case (idx)
      REG_GRADIENT_SCALE: grad_q16 = data;
      REG_AMBIENT_LEVEL: ambient_q12 = data[15:0];
      REG_SOURCE_LEVEL: source_q12 = data[15:0];
      REG_LIGHT_X: lx_q14 = data[15:0];
      REG_LIGHT_Y: ly_q14 = data[15:0];
      REG_LIGHT_Z: lz_q14 = data[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_all(logic [31:0] g, logic [31:0] a, logic [31:0] s,
                         logic [31:0] lx, logic [31:0] ly, logic [31:0] lz);
    s_axis_tvalid <= 1'b0;
    wait (brightness_q.size() == 0);
    repeat (160) @(posedge clk);
    write_reg(REG_GRADIENT_SCALE, g);
    write_reg(REG_AMBIENT_LEVEL, a);
    write_reg(REG_SOURCE_LEVEL, s);
    write_reg(REG_LIGHT_X, lx);
    write_reg(REG_LIGHT_Y, ly);
    write_reg(REG_LIGHT_Z, lz);
  endtask

  task automatic send_item(logic [31:0] sx, logic [31:0] sy, bit known, logic [15:0] want);
    bit r;
    int gap;
    brightness_q.push_back(known ? want : shade(sx, sy));
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {sy, sx};
    do begin
      @(negedge clk);
      r = s_axis_tready;
      @(posedge clk);
    end while (!r);
    gap = burst ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_slope();
    logic [31:0] picks[5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h1, 32'hffff_ffff};
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 524288) - 262144;
      2: return $urandom_range(0, 8192) - 4096;
      default: return picks[$urandom_range(0, 4)];
    endcase
  endfunction

  task automatic random_phase();
    burst = ($urandom_range(0, 3) == 0);
    repeat (ITEMS_PER_PHASE) send_item(rand_slope(), rand_slope(), 1'b0, 16'd0);
  endtask

  function automatic logic [31:0] rand_light();
    return $urandom_range(0, 32768) - 16384;
  endfunction

  initial begin
    bit v;
    logic [15:0] d;
    int gap;
    m_axis_tready <= 1'b0;
    forever begin
      gap = burst ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk);
        v = m_axis_tvalid;
        d = m_axis_tdata;
        @(posedge clk);
      end while (!v);
      if (brightness_q.size() == 0) begin
        report_mismatch("unexpected item", d, 16'd0);
      end else begin
        if (d !== brightness_q[0]) report_mismatch("brightness", d, brightness_q[0]);
        void'(brightness_q.pop_front());
      end
    end
  end

  initial begin
    errors = 0;
    burst = 1'b0;
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_GRADIENT_SCALE;
    cfg_data <= '0;
    grad_q16 = GRADIENT_RESET;
    ambient_q12 = AMBIENT_RESET;
    source_q12 = SOURCE_RESET;
    lx_q14 = LIGHT_X_RESET;
    ly_q14 = LIGHT_Y_RESET;
    lz_q14 = LIGHT_Z_RESET;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].sx, directed_rows[i].sy, directed_rows[i].known,
                directed_rows[i].brightness);

    // upper bits of the light word are dropped
    set_all(32'd1, 32'd0, 32'hffff_ffff, 32'hffff_4000, 32'd0, 32'd0);
    for (int i = 0; i < 4; i++) send_item(directed_rows[i].sx, 32'd0, 1'b0, 16'd0);
    random_phase();

    // zero gradient, full negative light beyond unit length, saturation
    set_all(32'd0, 32'hffff, 32'hffff, 32'hffff_c000, 32'hffff_c000, 32'hffff_c000);
    send_item(32'h8000_0000, 32'h8000_0000, 1'b1, 16'hffff);
    send_item(32'h0, 32'h0, 1'b1, 16'hffff);
    random_phase();

    set_all(32'hffff_ffff, 32'd4096, 32'd0, 32'd0, 32'd16384, 32'd0);
    write_reg(REG_SPARE_6, 32'hdead_beef);
    write_reg(REG_SPARE_7, 32'h1234_5678);
    random_phase();

    set_all(32'd65536, 32'd100, 32'd4096, 32'd9459, 32'd9459, 32'd9459);
    random_phase();

    set_all(32'd3000, 32'd0, 32'd65535, 32'd16384, 32'd16384, 32'd16384);
    random_phase();

    repeat (3) begin
      set_all($urandom, $urandom, $urandom, rand_light(), rand_light(), rand_light());
      random_phase();
    end

    s_axis_tvalid <= 1'b0;
    wait (brightness_q.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && brightness_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
